### src/obdcls_pkg.sv
package obdcls_pkg;

  // Identifier ranges used for diagnostic traffic on classic CAN.
  localparam logic [10:0] FUNC_REQ_ID   = 11'h7DF;
  localparam logic [10:0] PHYS_REQ_LO   = 11'h7E0;
  localparam logic [10:0] PHYS_REQ_HI   = 11'h7E7;
  localparam logic [10:0] RESP_ID_LO    = 11'h7E8;
  localparam logic [10:0] RESP_ID_HI    = 11'h7EF;

  // Service byte ranges.
  localparam logic [7:0]  REQ_MODE_LO   = 8'h01;
  localparam logic [7:0]  REQ_MODE_HI   = 8'h0A;
  localparam logic [7:0]  RESP_MODE_LO  = 8'h41;
  localparam logic [7:0]  RESP_MODE_HI  = 8'h4A;

  // Service modes: current data, and the modes that carry trouble codes in their responses.
  localparam logic [3:0]  MODE_CUR_DATA = 4'h1;
  localparam logic [3:0]  MODE_STORED   = 4'h3;
  localparam logic [3:0]  MODE_PENDING  = 4'h7;
  localparam logic [3:0]  MODE_PERM     = 4'hA;

  localparam logic [3:0]  MAX_DLC       = 4'd8;
  localparam int          MAX_CODES     = 3;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RESPONSE = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [10:0] can_id;
    logic [3:0]  frame_length;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
  } in_t;

  typedef struct packed {
    logic        is_diag_id;
    logic [1:0]  frame_kind;
    logic [3:0]  service_mode;
    logic [15:0] param_id;
    logic [3:0]  payload_length;
    logic        code_valid;
    logic [1:0]  code_category;
    logic [1:0]  code_first_digit;
    logic [11:0] code_low_digits;
    logic        last;
  } out_t;

  // One decoded frame: the fields shared by all its results plus the
  // compacted list of nonzero trouble codes.
  typedef struct packed {
    logic        is_diag_id;
    logic [1:0]  frame_kind;
    logic [3:0]  service_mode;
    logic [15:0] param_id;
    logic [3:0]  payload_length;
    logic [1:0]  code_count;
    logic [MAX_CODES-1:0][15:0] codes;
  } rec_t;

endpackage

### src/obd_frame_classify_dtc_extract.sv
// Channel   Ports                      Handshake                    Beat
// input     start, busy, in_data       start high and busy low      one CAN frame
// result    out_strobe, out_data       out_strobe high, one cycle   one result
//
// A frame is registered in the input register at its accepting edge, then decoded
// into a frame record that the record register takes once the emitter is free.
// Its results leave through an output register one per cycle. A frame yields one to
// three results, and a new frame can wait in the input register while an earlier one
// is sent. Reset (rst_n low, synchronous) empties every stage. The receiver cannot
// stall; busy is high only while a frame waits behind the codes of an earlier frame.
module obd_frame_classify_dtc_extract (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  obdcls_pkg::in_t   in_data,
  output logic              out_strobe,
  output obdcls_pkg::out_t  out_data
);

  // Input stage.
  obdcls_pkg::in_t  in_r;
  logic             in_vld_r;
  logic             in_vld_nxt;

  // Decoded frame record and the index of the next result to send.
  obdcls_pkg::rec_t dec;
  obdcls_pkg::rec_t rec_r;
  logic             rec_vld_r;
  logic             rec_vld_nxt;
  logic [1:0]       idx_r;
  logic [1:0]       idx_nxt;

  // Output register.
  obdcls_pkg::out_t out_r;
  obdcls_pkg::out_t out_nxt;
  logic             strobe_r;

  logic [1:0]       last_idx;
  logic             rec_done;
  logic             take;
  logic             accept;
  logic             has_codes;

  obdcls_decode u_decode (
    .frame (in_r),
    .rec   (dec)
  );

  always_comb begin
    has_codes = (rec_r.code_count != 2'd0);
    last_idx  = has_codes ? (rec_r.code_count - 2'd1) : 2'd0;
    rec_done  = rec_vld_r && (idx_r == last_idx);
    // The emitter takes a new record when empty or on its final result.
    take      = in_vld_r && (!rec_vld_r || rec_done);
    busy      = in_vld_r && !take;
    accept    = start && !busy;

    in_vld_nxt = accept ? 1'b1 : (take ? 1'b0 : in_vld_r);

    if (take) begin
      rec_vld_nxt = 1'b1;
      idx_nxt     = 2'd0;
    end else if (rec_done) begin
      rec_vld_nxt = 1'b0;
      idx_nxt     = 2'd0;
    end else begin
      rec_vld_nxt = rec_vld_r;
      idx_nxt     = rec_vld_r ? (idx_r + 2'd1) : idx_r;
    end

    out_nxt.is_diag_id       = rec_r.is_diag_id;
    out_nxt.frame_kind       = rec_r.frame_kind;
    out_nxt.service_mode     = rec_r.service_mode;
    out_nxt.param_id         = rec_r.param_id;
    out_nxt.payload_length   = rec_r.payload_length;
    out_nxt.code_valid       = has_codes;
    out_nxt.code_category    = has_codes ? rec_r.codes[idx_r][15:14] : 2'd0;
    out_nxt.code_first_digit = has_codes ? rec_r.codes[idx_r][13:12] : 2'd0;
    out_nxt.code_low_digits  = has_codes ? rec_r.codes[idx_r][11:0]  : 12'd0;
    out_nxt.last             = (idx_r == last_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      rec_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      strobe_r  <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      rec_vld_r <= rec_vld_nxt;
      idx_r     <= idx_nxt;
      strobe_r  <= rec_vld_r;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (take) begin
      rec_r <= dec;
    end
    if (rec_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

### src/obdcls_decode.sv
module obdcls_decode (
  input  obdcls_pkg::in_t  frame,
  output obdcls_pkg::rec_t rec
);

  logic [3:0]  dlc;
  logic        req_id;
  logic        resp_id;
  logic        obd;
  logic [7:0]  b1;
  logic [1:0]  kind;
  logic [3:0]  mode;
  logic [15:0] pid;
  logic [3:0]  plen;
  logic        dtc_mode;
  logic [2:0][15:0] raw;
  logic [2:0]  slot_ok;
  logic [2:0][15:0] packed_codes;
  logic [1:0]  cnt;

  always_comb begin
    dlc = (frame.frame_length > obdcls_pkg::MAX_DLC) ? obdcls_pkg::MAX_DLC
                                                     : frame.frame_length;
    req_id  = (frame.can_id == obdcls_pkg::FUNC_REQ_ID) ||
              (frame.can_id >= obdcls_pkg::PHYS_REQ_LO &&
               frame.can_id <= obdcls_pkg::PHYS_REQ_HI);
    resp_id = (frame.can_id >= obdcls_pkg::RESP_ID_LO &&
               frame.can_id <= obdcls_pkg::RESP_ID_HI);
    obd = (dlc >= 4'd2) && (req_id || resp_id);
    b1  = frame.byte_1;

    kind = obdcls_pkg::KIND_NONE;
    mode = 4'd0;
    pid  = 16'd0;
    plen = 4'd0;
    if (obd) begin
      plen = frame.byte_0[3:0];
      if (b1 >= obdcls_pkg::RESP_MODE_LO && b1 <= obdcls_pkg::RESP_MODE_HI) begin
        kind = obdcls_pkg::KIND_RESPONSE;
        mode = b1[3:0];
      end else if (b1 >= obdcls_pkg::REQ_MODE_LO && b1 <= obdcls_pkg::REQ_MODE_HI) begin
        kind = obdcls_pkg::KIND_REQUEST;
        mode = b1[3:0];
      end
      if (dlc >= 4'd3) begin
        pid = {8'd0, frame.byte_2};
      end
      // Mode 1 PID 0 carries a two-byte PID; the high byte is zero here.
      if (mode == obdcls_pkg::MODE_CUR_DATA && dlc >= 4'd4 && frame.byte_2 == 8'd0) begin
        pid = {frame.byte_2, frame.byte_3};
      end
    end

    dtc_mode = obd && (kind == obdcls_pkg::KIND_RESPONSE) &&
               (mode == obdcls_pkg::MODE_STORED || mode == obdcls_pkg::MODE_PENDING ||
                mode == obdcls_pkg::MODE_PERM);

    raw[0] = {frame.byte_2, frame.byte_3};
    raw[1] = {frame.byte_4, frame.byte_5};
    raw[2] = {frame.byte_6, frame.byte_7};

    // Slot i exists when the payload length covers it and both of its
    // bytes lie inside the frame; zero codes are dropped.
    slot_ok[0] = dtc_mode && (plen >= 4'd3) && (dlc > 4'd3) && (raw[0] != 16'd0);
    slot_ok[1] = dtc_mode && (plen >= 4'd5) && (dlc > 4'd5) && (raw[1] != 16'd0);
    slot_ok[2] = dtc_mode && (plen >= 4'd7) && (dlc > 4'd7) && (raw[2] != 16'd0);

    packed_codes = '0;
    cnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (slot_ok[i]) begin
        packed_codes[cnt] = raw[i];
        cnt = cnt + 2'd1;
      end
    end

    rec.is_diag_id     = req_id || resp_id;
    rec.frame_kind     = kind;
    rec.service_mode   = mode;
    rec.param_id       = pid;
    rec.payload_length = plen;
    rec.code_count     = cnt;
    rec.codes          = packed_codes;
  end

endmodule
